// ===== rtl/core/wgm_pkg.sv =====
// ----------------------------------------------------------------------------
// wgm_pkg - shared types and constants for the wildcard glob matcher
// Item function codes, wildcard byte codes, and the control and link structs
// passed between the top level and the cells.
// ----------------------------------------------------------------------------
package wgm_pkg;

  localparam int MASK_CAPACITY = 32;

  localparam logic [7:0] CH_ANY_ONE = 8'h3F;  // '?'
  localparam logic [7:0] CH_ANY_RUN = 8'h2A;  // '*'
  localparam logic [7:0] FOLD_MASK  = 8'hDF;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_NAME   = 2'd2,
    FUNC_END    = 2'd3
  } func_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic clear;    // drop the stored mask
    logic append;   // store one more mask byte
    logic step;     // advance on a name byte
    logic restart;  // only position zero active
  } cell_ctrl_t;

  // handed from cell p to cell p+1
  typedef struct packed {
    logic valid;    // position p holds a mask byte
    logic carry;    // '*' at active position p: p+1 active too
    logic step;     // byte matched at position p: p+1 active next
  } link_t;

endpackage

// ===== rtl/core/wgm_cell.sv =====
// ----------------------------------------------------------------------------
// wgm_cell - one mask position of the glob matcher
// Holds one mask byte, its valid flag and the activity flag of the position.
// ----------------------------------------------------------------------------
module wgm_cell #(
  parameter bit IS_HEAD = 1'b0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  wgm_pkg::cell_ctrl_t ctrl,
  input  logic [7:0]         name_char,
  input  logic               case_fold,
  input  wgm_pkg::link_t     link_in,
  output wgm_pkg::link_t     link_out,
  output logic               hit
);

  logic       valid_r, valid_nxt;
  logic       act_r, act_nxt;
  logic [7:0] byte_r;
  logic       is_end, closed, star, fits;

  // first empty slot: previous position filled, this one not
  assign is_end = link_in.valid & ~valid_r;
  assign closed = act_r | link_in.carry;
  assign star   = valid_r & (byte_r == wgm_pkg::CH_ANY_RUN);

  always_comb begin
    if (byte_r == wgm_pkg::CH_ANY_ONE) begin
      fits = 1'b1;
    end else if (case_fold) begin
      fits = (byte_r & wgm_pkg::FOLD_MASK) == (name_char & wgm_pkg::FOLD_MASK);
    end else begin
      fits = byte_r == name_char;
    end
  end

  assign link_out.valid = valid_r;
  assign link_out.carry = closed & star;
  assign link_out.step  = closed & valid_r & ~star & fits;
  assign hit            = closed & is_end;

  always_comb begin
    valid_nxt = valid_r;
    if (ctrl.clear) begin
      valid_nxt = 1'b0;
    end else if (ctrl.append && is_end) begin
      valid_nxt = 1'b1;
    end
    act_nxt = act_r;
    if (ctrl.restart) begin
      act_nxt = IS_HEAD;
    end else if (ctrl.step) begin
      act_nxt = (closed & star) | link_in.step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      act_r   <= IS_HEAD;
    end else begin
      valid_r <= valid_nxt;
      act_r   <= act_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.append && is_end) begin
      byte_r <= name_char;
    end
  end

endmodule

// ===== rtl/core/wildcard_glob_matcher_core.sv =====
// ----------------------------------------------------------------------------
// wildcard_glob_matcher_core - streaming glob matcher ('*' and '?')
// Loads a mask byte by byte, then matches streamed name bytes against it.
// ----------------------------------------------------------------------------
// Takes one item per clock, every clock, as long as the result register is
// free or being drained. Each item does its work in the cycle it is
// accepted: a row of MASK_CAPACITY cells, one per mask position, updates
// all active positions at once, with '*' closure rippling down the row like
// a carry chain. Only an end-of-name item gives a result, registered and
// held in the output register until taken. Appending beyond MASK_CAPACITY
// bytes drops the byte and raises mask_overflow until the next clear.
// Clearing or appending to the mask, and every end of name, restart name
// matching. No clearing pass after reset.
module wildcard_glob_matcher_core #(
  parameter int MASK_CAPACITY = wgm_pkg::MASK_CAPACITY
) (
  input  logic       clk,
  input  logic       rst_n,
  // configuration
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,   // case_fold
  // input items
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,      // [7:0] char_value
  input  logic [1:0] in_tuser,      // [1:0] func
  // result items
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata      // [0] match, [1] mask_overflow, [7:2] zero
);

  logic                case_fold_r;
  logic                overflow_r, overflow_nxt;
  logic                end_act_r, end_act_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_match_r, out_match_nxt;
  logic                out_ovf_r, out_ovf_nxt;
  logic                fire;
  logic                is_end_item;
  wgm_pkg::func_t      func;
  wgm_pkg::cell_ctrl_t ctrl;
  wgm_pkg::link_t      link [0:MASK_CAPACITY];
  logic [MASK_CAPACITY:0] hit;
  logic                end_closed;

  assign in_tready = ~out_valid_r | out_tready;
  assign fire      = in_tvalid & in_tready;
  assign func      = wgm_pkg::func_t'(in_tuser);

  // item decode
  always_comb begin
    ctrl        = '0;
    is_end_item = 1'b0;
    unique case (func)
      wgm_pkg::FUNC_CLEAR: begin
        ctrl.clear   = fire;
        ctrl.restart = fire;
      end
      wgm_pkg::FUNC_APPEND: begin
        ctrl.append  = fire;
        ctrl.restart = fire;
      end
      wgm_pkg::FUNC_NAME: begin
        ctrl.step = fire;
      end
      wgm_pkg::FUNC_END: begin
        ctrl.restart = fire;
        is_end_item  = fire;
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

  // head of the row: position zero always sits after a "filled" slot
  assign link[0] = '{valid: 1'b1, carry: 1'b0, step: 1'b0};

  for (genvar p = 0; p < MASK_CAPACITY; p++) begin : g_cell
    wgm_cell #(
      .IS_HEAD (p == 0)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .name_char (in_tdata),
      .case_fold (case_fold_r),
      .link_in   (link[p]),
      .link_out  (link[p+1]),
      .hit       (hit[p])
    );
  end

  // position past a full store; reachable only when every slot is filled
  assign end_closed         = end_act_r | link[MASK_CAPACITY].carry;
  assign hit[MASK_CAPACITY] = end_closed & link[MASK_CAPACITY].valid;

  always_comb begin
    end_act_nxt = end_act_r;
    if (ctrl.restart) begin
      end_act_nxt = 1'b0;
    end else if (ctrl.step) begin
      end_act_nxt = link[MASK_CAPACITY].step;
    end

    overflow_nxt = overflow_r;
    if (ctrl.clear) begin
      overflow_nxt = 1'b0;
    end else if (ctrl.append && link[MASK_CAPACITY].valid) begin
      overflow_nxt = 1'b1;   // store full, byte dropped
    end

    out_valid_nxt = out_valid_r;
    out_match_nxt = out_match_r;
    out_ovf_nxt   = out_ovf_r;
    if (is_end_item) begin
      out_valid_nxt = 1'b1;
      out_match_nxt = |hit;
      out_ovf_nxt   = overflow_r;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      case_fold_r <= 1'b0;
      overflow_r  <= 1'b0;
      end_act_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case_fold_r <= cfg_wr_data;
      end
      overflow_r  <= overflow_nxt;
      end_act_r   <= end_act_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_match_r <= out_match_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_ovf_r, out_match_r};

endmodule
